FILE: src/mhpq_pkg.sv
package mhpq_pkg;

  // Store geometry. The count needs one more value than the address.
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = ADDR_W + 2;
  localparam int DATA_W   = 32;

  localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_PEEK   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } mhpq_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } mhpq_status_t;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [DATA_W-1:0] value;
  } mhpq_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         item_count;
    logic                     is_empty;
  } mhpq_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_FINISH
  } mhpq_state_t;

  typedef enum logic [1:0] {
    RD_PARENT,
    RD_ROOT_LAST,
    RD_CHILDREN
  } mhpq_rd_mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic          load_in;
    mhpq_rd_mode_t rd_mode;
    logic          wr_val;
    logic          wr_parent;
    logic          wr_cand;
    logic          pos_up;
    logic          pos_down;
    logic          start_insert;
    logic          start_remove;
    logic          take_root;
    logic          set_empty;
    logic          set_full;
    logic          out_load;
  } mhpq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       pos_zero;
    logic       up_swap;
    logic       leaf;
    logic       dn_swap;
    logic       out_free;
  } mhpq_sts_t;

endpackage

FILE: src/mhpq_datapath.sv
module mhpq_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  mhpq_pkg::mhpq_in_t  in_data,
  input  mhpq_pkg::mhpq_cmd_t cmd,
  output mhpq_pkg::mhpq_sts_t sts,
  input  logic                out_ready,
  output logic                out_valid,
  output mhpq_pkg::mhpq_out_t out_data
);
  import mhpq_pkg::*;

  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rd_a_q;
  logic signed [DATA_W-1:0] rd_b_q;

  logic [1:0]               op_r;
  logic signed [DATA_W-1:0] val_r;
  logic [CNT_W-1:0]         count_r;
  logic [ADDR_W-1:0]        pos_r;
  logic signed [DATA_W-1:0] res_r;
  logic [1:0]               status_r;
  logic                     out_valid_r;
  mhpq_out_t                out_data_r;

  logic [ADDR_W-1:0]        pos_m1;
  logic [ADDR_W-1:0]        parent;
  logic [IDX_W-1:0]         left;
  logic [IDX_W-1:0]         right;
  logic [IDX_W-1:0]         count_ext;
  logic                     pick_right;
  logic signed [DATA_W-1:0] cand;
  logic [ADDR_W-1:0]        cand_idx;
  logic [CNT_W-1:0]         count_m1;
  logic [ADDR_W-1:0]        addr_a;
  logic [ADDR_W-1:0]        addr_b;
  logic                     wr_en;
  logic signed [DATA_W-1:0] wr_data;

  assign pos_m1     = pos_r - 1'b1;
  assign parent     = ADDR_W'(pos_m1 >> 1);
  assign left       = {1'b0, pos_r, 1'b1};
  assign right      = left + 1'b1;
  assign count_ext  = IDX_W'(count_r);
  // The right child wins only when it exists and is strictly larger than the left.
  assign pick_right = (right < count_ext) && (rd_b_q > rd_a_q);
  assign cand       = pick_right ? rd_b_q : rd_a_q;
  assign cand_idx   = pick_right ? right[ADDR_W-1:0] : left[ADDR_W-1:0];
  assign count_m1   = count_r - 1'b1;

  always_comb begin
    unique case (cmd.rd_mode)
      RD_PARENT: begin
        addr_a = parent;
        addr_b = parent;
      end
      RD_ROOT_LAST: begin
        addr_a = '0;
        addr_b = count_m1[ADDR_W-1:0];
      end
      RD_CHILDREN: begin
        addr_a = left[ADDR_W-1:0];
        addr_b = right[ADDR_W-1:0];
      end
      default: begin
        addr_a = '0;
        addr_b = '0;
      end
    endcase
  end

  assign wr_en   = cmd.wr_val || cmd.wr_parent || cmd.wr_cand;
  assign wr_data = cmd.wr_parent ? rd_a_q : (cmd.wr_cand ? cand : val_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos_r] <= wr_data;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start_insert) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.start_remove) begin
        count_r <= count_m1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r     <= in_data.command;
      val_r    <= in_data.value;
      res_r    <= '0;
      status_r <= ST_OK;
    end
    if (cmd.start_insert) begin
      pos_r <= count_r[ADDR_W-1:0];
    end
    if (cmd.take_root) begin
      res_r <= rd_a_q;
    end
    if (cmd.start_remove) begin
      val_r <= rd_b_q;
      pos_r <= '0;
    end
    if (cmd.pos_up) begin
      pos_r <= parent;
    end
    if (cmd.pos_down) begin
      pos_r <= cand_idx;
    end
    if (cmd.set_empty) begin
      res_r    <= INT_MIN;
      status_r <= ST_EMPTY;
    end
    if (cmd.set_full) begin
      status_r <= ST_FULL;
    end
    if (cmd.out_load) begin
      out_data_r.result_value <= res_r;
      out_data_r.status       <= status_r;
      out_data_r.item_count   <= count_r;
      out_data_r.is_empty     <= (count_r == '0);
    end
  end

  always_comb begin
    sts.op       = op_r;
    sts.full     = (count_r == CNT_W'(CAPACITY));
    sts.empty    = (count_r == '0);
    sts.pos_zero = (pos_r == '0);
    sts.up_swap  = (val_r > rd_a_q);
    sts.leaf     = (left >= count_ext);
    sts.dn_swap  = (cand > val_r);
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/mhpq_ctrl.sv
module mhpq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mhpq_pkg::mhpq_sts_t sts,
  output mhpq_pkg::mhpq_cmd_t cmd
);
  import mhpq_pkg::*;

  mhpq_state_t state_r;
  mhpq_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.rd_mode = RD_CHILDREN;
    in_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.op) inside
          OP_INSERT: begin
            if (sts.full) begin
              cmd.set_full = 1'b1;
              state_nxt    = S_FINISH;
            end else begin
              cmd.start_insert = 1'b1;
              state_nxt        = S_UP_RD;
            end
          end
          OP_PEEK, OP_REMOVE: begin
            if (sts.empty) begin
              cmd.set_empty = 1'b1;
              state_nxt     = S_FINISH;
            end else begin
              cmd.rd_mode = RD_ROOT_LAST;
              state_nxt   = S_FETCH;
            end
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_FETCH: begin
        cmd.take_root = 1'b1;
        if (sts.op == OP_REMOVE) begin
          cmd.start_remove = 1'b1;
          state_nxt        = S_DN_RD;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_UP_RD: begin
        if (sts.pos_zero) begin
          cmd.wr_val = 1'b1;
          state_nxt  = S_FINISH;
        end else begin
          cmd.rd_mode = RD_PARENT;
          state_nxt   = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_swap) begin
          cmd.wr_parent = 1'b1;
          cmd.pos_up    = 1'b1;
          state_nxt     = S_UP_RD;
        end else begin
          cmd.wr_val = 1'b1;
          state_nxt  = S_FINISH;
        end
      end
      S_DN_RD: begin
        if (sts.leaf) begin
          cmd.wr_val = 1'b1;
          state_nxt  = S_FINISH;
        end else begin
          cmd.rd_mode = RD_CHILDREN;
          state_nxt   = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (sts.dn_swap) begin
          cmd.wr_cand  = 1'b1;
          cmd.pos_down = 1'b1;
          state_nxt    = S_DN_RD;
        end else begin
          cmd.wr_val = 1'b1;
          state_nxt  = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/max_heap_priority_queue_unit.sv
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_ready  mhpq_in_t: command, value
// out_     output     out_valid/out_ready  mhpq_out_t: result_value, status, item_count, is_empty
//
// One transaction is in flight at a time. After the accepting edge the controller decodes
// the command; peek then fetches the root, insert sifts the new value up level by level,
// and remove fetches the root and last entry and sifts down, before the result register is loaded.
// Reset (rst_n low, synchronous) empties the heap; the store itself is not cleared. A
// stalled result stays in the output register and holds the controller until it is taken.
module max_heap_priority_queue_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mhpq_pkg::mhpq_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mhpq_pkg::mhpq_out_t out_data
);
  import mhpq_pkg::*;

  mhpq_cmd_t cmd;
  mhpq_sts_t sts;

  // The controller sequences each command: decode, optional root fetch, then for an insert
  // or remove the sift-up or sift-down walk, and finally loading the result register.
  mhpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the heap store, the element count, the element being sifted
  // and its position, and the output register.
  mhpq_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // The count reported never exceeds the capacity.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.item_count <= CNT_W'(CAPACITY)))
    else $error("item_count above capacity");

  // The empty flag agrees with the count.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_empty == (out_data.item_count == '0)))
    else $error("is_empty disagrees with item_count");

  // An empty status always carries the most negative value.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_EMPTY)) |-> (out_data.result_value == INT_MIN))
    else $error("empty result without most negative value");

  // Only one transaction is taken in at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while busy");

endmodule

FILE: bench/mhpq_scoreboard_pkg.sv
`timescale 1ns / 1ps

package mhpq_scoreboard_pkg;
  import mhpq_pkg::*;

  // Keeps a copy of the heap and predicts the response to every accepted command.
  class heap_order_scoreboard;
    logic signed [DATA_W-1:0] slots [CAPACITY];
    int unsigned count;
    mhpq_out_t expected_responses [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned dropped_inserts;
    int unsigned empty_reads;
    int unsigned peak_count;

    function new();
      count = 0;
      mismatches = 0;
      checked = 0;
      dropped_inserts = 0;
      empty_reads = 0;
      peak_count = 0;
    endfunction

    function void swap_slots(int a, int b);
      logic signed [DATA_W-1:0] held;
      held = slots[a];
      slots[a] = slots[b];
      slots[b] = held;
    endfunction

    function void accept_command(mhpq_in_t item);
      mhpq_out_t resp;
      int pos;
      int parent;
      int left;
      int right;
      int best;
      resp.result_value = '0;
      resp.status = ST_OK;
      case (mhpq_op_t'(item.command)) inside
        OP_INSERT: begin
          if (count >= CAPACITY) begin
            resp.status = ST_FULL;
            dropped_inserts++;
          end else begin
            slots[count] = item.value;
            pos = count;
            count++;
            if (count > peak_count) peak_count = count;
            while (pos > 0) begin
              parent = (pos - 1) / 2;
              if (slots[pos] > slots[parent]) begin
                swap_slots(pos, parent);
                pos = parent;
              end else begin
                break;
              end
            end
          end
        end
        OP_PEEK, OP_REMOVE: begin
          if (count == 0) begin
            resp.result_value = INT_MIN;
            resp.status = ST_EMPTY;
            empty_reads++;
          end else begin
            resp.result_value = slots[0];
            if (mhpq_op_t'(item.command) == OP_REMOVE) begin
              count--;
              slots[0] = slots[count];
              pos = 0;
              forever begin
                left = 2 * pos + 1;
                right = left + 1;
                best = pos;
                if (left >= count) break;
                if (slots[left] > slots[best]) best = left;
                if (right < count && slots[right] > slots[best]) best = right;
                if (best == pos) break;
                swap_slots(pos, best);
                pos = best;
              end
            end
          end
        end
        default: begin
        end
      endcase
      resp.item_count = CNT_W'(count);
      resp.is_empty = (count == 0);
      expected_responses = {expected_responses, resp};
    endfunction

    function void check_response(mhpq_out_t got);
      mhpq_out_t want;
      if (expected_responses.size() == 0) begin
        $error("response with no command outstanding: result_value %0d status %0d",
               got.result_value, got.status);
        mismatches++;
        return;
      end
      want = expected_responses.pop_front();
      checked++;
      if (got.result_value !== want.result_value) begin
        $error("result_value: expected %0d, got %0d", want.result_value, got.result_value);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.item_count !== want.item_count) begin
        $error("item_count: expected %0d, got %0d", want.item_count, got.item_count);
        mismatches++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_responses.size();
    endfunction
  endclass

endpackage

FILE: bench/max_heap_priority_queue_unit_test.sv
`timescale 1ns / 1ps

module max_heap_priority_queue_unit_test;
  import mhpq_pkg::*;
  import mhpq_scoreboard_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 11;
  localparam int ITEMS_PER_PHASE = 200;
  // Stalls on either side at 54 per cent rarely last long, so this leaves
  // a wide margin even for the slowest command.
  localparam int QUIET_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int NUM_PHASES      = 4;

  // Sender idle and receiver stall rates, in per cent, for each phase.
  localparam int SENDER_IDLE [NUM_PHASES]   = '{0, 54, 0, 8};
  localparam int RECEIVER_STALL [NUM_PHASES] = '{0, 0, 54, 8};

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  mhpq_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  mhpq_out_t out_data;

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  // The random stimulus alternates between filling the heap and draining it.
  bit filling = 1'b1;

  heap_order_scoreboard heap_sb;

  max_heap_priority_queue_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Presents one command at a falling edge, after any idle cycles the current
  // phase calls for, and holds it until the transaction is accepted. Valid is
  // left high on return so that a following command can go out back to back.
  task automatic issue_command(input mhpq_op_t op, input logic signed [DATA_W-1:0] value);
    mhpq_in_t item;
    item.command = op;
    item.value = value;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data = item;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    heap_sb.accept_command(item);
  endtask

  // Values lean towards the extremes and a narrow band around zero, so that
  // equal keys meet often and the strict comparisons in both sifts matter.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return INT_MIN;
      1:       return 32'sh7fff_ffff;
      2, 3, 4: return DATA_W'(int'($urandom_range(15)) - 8);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Mostly well-formed runs that walk the heap to full and back to empty, with
  // peeks, unused codes and commands against the current direction mixed in.
  // At either end the direction turns only at random, so that inserts into a
  // full heap and reads of an empty one are tried several times.
  function automatic mhpq_op_t pick_command();
    int unsigned roll;
    if (filling && heap_sb.count == CAPACITY && $urandom_range(3) == 0) filling = 1'b0;
    else if (!filling && heap_sb.count == 0 && $urandom_range(2) == 0) filling = 1'b1;
    roll = $urandom_range(99);
    if (roll < 4) return OP_NOP;
    if (roll < 14) return OP_PEEK;
    if (roll < 26) return filling ? OP_REMOVE : OP_INSERT;
    return filling ? OP_INSERT : OP_REMOVE;
  endfunction

  // The receiver decides afresh at every falling edge whether to take a result.
  initial begin
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Every result transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) heap_sb.check_response(out_data);
  end

  // Ends the run if neither channel completes a transaction for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("max_heap_priority_queue_unit_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    heap_sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opening: every command on an empty heap, then the extreme
    // values, equal keys and alternating bit patterns, drained past empty.
    issue_command(OP_NOP, 32'sd0);
    issue_command(OP_PEEK, 32'sd5);
    issue_command(OP_REMOVE, 32'sd5);
    issue_command(OP_INSERT, 32'sd0);
    issue_command(OP_INSERT, 32'sh7fff_ffff);
    issue_command(OP_INSERT, INT_MIN);
    issue_command(OP_INSERT, -32'sd1);
    issue_command(OP_INSERT, 32'sd1);
    issue_command(OP_INSERT, 32'sh5555_5555);
    issue_command(OP_INSERT, 32'shaaaa_aaaa);
    issue_command(OP_INSERT, 32'sd1);
    issue_command(OP_INSERT, -32'sd1);
    issue_command(OP_PEEK, 32'sd0);
    issue_command(OP_NOP, -32'sd1);
    repeat (10) issue_command(OP_REMOVE, 32'sd0);
    issue_command(OP_PEEK, 32'sd0);

    // Random part, one phase per idling pattern; the heap carries over.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      sender_idle_pct = SENDER_IDLE[phase];
      receiver_stall_pct = RECEIVER_STALL[phase];
      repeat (ITEMS_PER_PHASE) issue_command(pick_command(), pick_value());
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (heap_sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d responses over %0d idling patterns; the heap peaked at %0d entries.",
             heap_sb.checked, NUM_PHASES, heap_sb.peak_count);
    $display("Inserts dropped on a full heap: %0d; reads of an empty heap: %0d.",
             heap_sb.dropped_inserts, heap_sb.empty_reads);
    if (heap_sb.mismatches == 0) begin
      $display("max_heap_priority_queue_unit_test OK");
    end else begin
      $display("max_heap_priority_queue_unit_test NOT OK");
    end
    $finish;
  end

endmodule
